### rtl/dpsm_pkg.sv
// Package for the demand-paged sparse memory: sizes, derived widths and control structs.
package dpsm_pkg;

  localparam int PAGE_BITS  = 8;
  localparam int NUM_FRAMES = 16;

  localparam int ADDR_W     = 64;
  localparam int WORD_W     = 64;
  localparam int TAG_W      = ADDR_W - PAGE_BITS;
  localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int MEM_DEPTH  = NUM_FRAMES << PAGE_BITS;
  localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int IN_TDATA_W  = 2 * WORD_W;
  localparam int OUT_TDATA_W = 72;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic clear_en;
    logic capture;
    logic fire;
  } dpsm_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dpsm_status_t;

endpackage

### rtl/dpsm_ctrl.sv
// Controller state machine: clearing sweep, item capture and memory access sequencing.
module dpsm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  dpsm_pkg::dpsm_status_t status,
  output dpsm_pkg::dpsm_cmd_t    cmd
);
  import dpsm_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    in_tready    = (state_r == S_IDLE);
    cmd.clear_en = (state_r == S_CLEAR);
    cmd.capture  = in_tvalid && (state_r == S_IDLE);
    cmd.fire     = (state_r == S_ACCESS) && (!out_valid_r || out_tready);
    out_tvalid   = out_valid_r;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_ACCESS;
        end
      end
      S_ACCESS: begin
        if (cmd.fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/dpsm_datapath.sv
// Datapath: frame tag match, frame allocation, word store and result registers.
module dpsm_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dpsm_pkg::dpsm_cmd_t                  cmd,
  output dpsm_pkg::dpsm_status_t               status,
  input  logic                                 in_op,
  input  logic [dpsm_pkg::ADDR_W-1:0]          in_address,
  input  logic [dpsm_pkg::WORD_W-1:0]          in_write_data,
  output logic [dpsm_pkg::WORD_W-1:0]          out_read_data,
  output logic                                 out_mapped,
  output logic                                 out_allocated,
  output logic                                 out_out_of_frames
);
  import dpsm_pkg::*;

  // frame table
  logic [NUM_FRAMES-1:0] frame_valid_r;
  logic [TAG_W-1:0]      frame_tag_r [NUM_FRAMES];
  logic [CNT_W-1:0]      free_cnt_r;

  // clearing sweep
  logic [MEM_AW-1:0]     clr_cnt_r;

  // captured access
  logic [TAG_W-1:0]      page_r;
  logic [PAGE_BITS-1:0]  offset_r;
  logic [FRAME_W-1:0]    frame_r;
  logic [WORD_W-1:0]     data_r;
  logic                  rd_r;
  logic                  we_r;
  logic                  hit_r;
  logic                  alloc_r;
  logic                  full_r;

  // result
  logic                  res_rd_r;
  logic                  res_mapped_r;
  logic                  res_alloc_r;
  logic                  res_full_r;
  logic [WORD_W-1:0]     mem_rd_r;

  logic [WORD_W-1:0]     mem [MEM_DEPTH];

  logic [TAG_W-1:0]      in_page;
  logic                  hit;
  logic [FRAME_W-1:0]    hit_idx;
  logic                  avail;
  logic                  mem_we;
  logic [MEM_AW-1:0]     mem_addr;
  logic [MEM_AW-1:0]     acc_addr;
  logic [WORD_W-1:0]     mem_wdata;

  assign in_page = in_address[ADDR_W-1:PAGE_BITS];
  assign avail   = (free_cnt_r < CNT_W'(NUM_FRAMES));

  // match the page against all valid frames, lowest index wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
      if (frame_valid_r[f] && (frame_tag_r[f] == in_page)) begin
        hit     = 1'b1;
        hit_idx = FRAME_W'(f);
      end
    end
  end

  assign status.clear_last = (clr_cnt_r == MEM_AW'(MEM_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r   <= in_page;
      offset_r <= in_address[PAGE_BITS-1:0];
      data_r   <= in_write_data;
      frame_r  <= hit ? hit_idx : FRAME_W'(free_cnt_r);
      rd_r     <= (in_op == OP_READ) && hit;
      we_r     <= (in_op == OP_WRITE) && (hit || avail);
      hit_r    <= hit;
      alloc_r  <= (in_op == OP_WRITE) && !hit && avail;
      full_r   <= (in_op == OP_WRITE) && !hit && !avail;
    end
  end

  // allocate a frame on a write miss
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      free_cnt_r    <= '0;
    end else if (cmd.fire && alloc_r) begin
      frame_valid_r[frame_r] <= 1'b1;
      free_cnt_r             <= free_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && alloc_r) begin
      frame_tag_r[frame_r] <= page_r;
    end
  end

  assign acc_addr  = MEM_AW'({frame_r, offset_r});
  assign mem_we    = cmd.clear_en || (cmd.fire && we_r);
  assign mem_addr  = cmd.clear_en ? clr_cnt_r : acc_addr;
  assign mem_wdata = cmd.clear_en ? '0 : data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.fire && rd_r) begin
      mem_rd_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      res_rd_r     <= rd_r;
      res_mapped_r <= hit_r;
      res_alloc_r  <= alloc_r;
      res_full_r   <= full_r;
    end
  end

  assign out_read_data     = res_rd_r ? mem_rd_r : '0;
  assign out_mapped        = res_mapped_r;
  assign out_allocated     = res_alloc_r;
  assign out_out_of_frames = res_full_r;

endmodule

### rtl/demand_paged_sparse_memory_unit.sv
// Top level of the demand-paged sparse memory: controller and datapath joined.
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   in_tuser: op; in_tdata: address, write_data
//   out_     out  out_tvalid/out_tready out_tdata: read_data, mapped, allocated,
//                                       out_of_frames
//
// The tag match over all frames runs in the accept cycle; the word store is read
// or written in the access state, which holds while a waiting result is not yet taken.
// After reset a clearing sweep zeroes all NUM_FRAMES << PAGE_BITS words (4096) of
// the word store, one word a cycle; no item is accepted meanwhile.
// A new item is accepted while a result waits; its store access holds until
// the waiting result is taken.
module demand_paged_sparse_memory_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dpsm_pkg::IN_TDATA_W-1:0]     in_tdata,   // address, write_data
  input  logic                                in_tuser,   // op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dpsm_pkg::OUT_TDATA_W-1:0]    out_tdata   // read_data, mapped, allocated,
                                                          // out_of_frames, zero fill
);
  import dpsm_pkg::*;

  dpsm_cmd_t          cmd;
  dpsm_status_t       status;
  logic [WORD_W-1:0]  read_data;
  logic               mapped;
  logic               allocated;
  logic               out_of_frames;

  dpsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  dpsm_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_op             (in_tuser),
    .in_address        (in_tdata[ADDR_W-1:0]),
    .in_write_data     (in_tdata[ADDR_W+WORD_W-1:ADDR_W]),
    .out_read_data     (read_data),
    .out_mapped        (mapped),
    .out_allocated     (allocated),
    .out_out_of_frames (out_of_frames)
  );

  assign out_tdata = {(OUT_TDATA_W - WORD_W - 3)'(0), out_of_frames, allocated, mapped,
                      read_data};

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the demand-paged sparse memory: directed accesses, then random ones.
module tb_top;
  import dpsm_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              mapped;
    logic              allocated;
    logic              out_of_frames;
  } mem_result_t;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
    bit                typed;
    mem_result_t       want;
  } access_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // address, write_data
  logic                   in_tuser;   // op
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // read_data, mapped, allocated, out_of_frames, zero fill

  demand_paged_sparse_memory_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  logic              frame_live [NUM_FRAMES];
  logic [TAG_W-1:0]  frame_tag  [NUM_FRAMES];
  logic [WORD_W-1:0] word_store [MEM_DEPTH];
  int                frames_taken;

  mem_result_t       pending_results [$];
  access_row_t       directed_rows [$];
  logic [ADDR_W-1:0] page_pool [$];
  int                error_count = 0;

  function automatic void clear_page_table();
    for (int f = 0; f < NUM_FRAMES; f++) begin
      frame_live[f] = 1'b0;
      frame_tag[f]  = '0;
    end
    for (int w = 0; w < MEM_DEPTH; w++) word_store[w] = '0;
    frames_taken = 0;
  endfunction

  function automatic mem_result_t access_memory(input logic op, input logic [ADDR_W-1:0] addr,
                                                input logic [WORD_W-1:0] wdata);
    logic [TAG_W-1:0] page;
    int               hit;
    int               slot;
    mem_result_t      res;
    page = addr[ADDR_W-1:PAGE_BITS];
    hit  = -1;
    res  = '0;
    for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
      if (frame_live[f] && frame_tag[f] == page) hit = f;
    end
    res.mapped = (hit >= 0);
    if (op == OP_READ) begin
      if (hit >= 0) res.read_data = word_store[(hit << PAGE_BITS) | int'(addr[PAGE_BITS-1:0])];
    end else if (hit >= 0) begin
      word_store[(hit << PAGE_BITS) | int'(addr[PAGE_BITS-1:0])] = wdata;
    end else if (frames_taken < NUM_FRAMES) begin
      slot = frames_taken;
      frame_live[slot] = 1'b1;
      frame_tag[slot]  = page;
      word_store[(slot << PAGE_BITS) | int'(addr[PAGE_BITS-1:0])] = wdata;
      frames_taken++;
      res.allocated = 1'b1;
    end else begin
      res.out_of_frames = 1'b1;
    end
    return res;
  endfunction

  function automatic void add_row(input logic op, input logic [ADDR_W-1:0] addr,
                                  input logic [WORD_W-1:0] wdata, input bit typed,
                                  input logic [WORD_W-1:0] rd, input logic m, input logic a,
                                  input logic o);
    access_row_t row;
    row.op    = op;
    row.addr  = addr;
    row.wdata = wdata;
    row.typed = typed;
    row.want  = '{rd, m, a, o};
    directed_rows.push_back(row);
    if (typed && a) page_pool.push_back(addr);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] wdata, input int gap, input bit typed,
                             input mem_result_t want);
    mem_result_t model_res;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {wdata, addr};
    do @(posedge clk); while (!in_tready);
    model_res = access_memory(op, addr, wdata);
    pending_results.push_back(typed ? want : model_res);
  endtask

  always @(posedge clk) begin
    mem_result_t got;
    mem_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[63:0], out_tdata[64], out_tdata[65], out_tdata[66]};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[63:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.mapped !== want.mapped)
          report_mismatch("mapped", 64'(got.mapped), 64'(want.mapped));
        if (got.allocated !== want.allocated)
          report_mismatch("allocated", 64'(got.allocated), 64'(want.allocated));
        if (got.out_of_frames !== want.out_of_frames)
          report_mismatch("out_of_frames", 64'(got.out_of_frames), 64'(want.out_of_frames));
      end
    end
  end

  initial begin
    logic [7:0] ready_pattern;
    int         phase;
    out_tready    = 1'b0;
    ready_pattern = 8'hFF;
    phase         = 0;
    forever begin
      @(negedge clk);
      if (phase == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = 8'hFF;
          default: ready_pattern = 8'($urandom) | 8'h01;
        endcase
      end
      out_tready <= ready_pattern[phase % 8];
      phase = (phase + 1) % 64;
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int                burst_left;
    int                gap;
    int                pick;
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
    access_row_t       row;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = OP_READ;
    in_tdata  = '0;
    clear_page_table();

    add_row(OP_READ,  64'h0, 64'h0, 1, 64'h0, 1'b0, 1'b0, 1'b0);
    add_row(OP_READ,  '1, 64'h0, 1, 64'h0, 1'b0, 1'b0, 1'b0);
    add_row(OP_WRITE, '1, '1, 1, 64'h0, 1'b0, 1'b1, 1'b0);
    add_row(OP_READ,  '1, 64'h0, 1, '1, 1'b1, 1'b0, 1'b0);
    add_row(OP_READ,  64'hFFFF_FFFF_FFFF_FF00, '1, 1, 64'h0, 1'b1, 1'b0, 1'b0);
    add_row(OP_WRITE, 64'h0, 64'h0, 1, 64'h0, 1'b0, 1'b1, 1'b0);
    add_row(OP_WRITE, 64'hFF, 64'hA5A5_A5A5_A5A5_A5A5, 1, 64'h0, 1'b1, 1'b0, 1'b0);
    add_row(OP_READ,  64'hFF, 64'h0, 1, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < NUM_FRAMES - 2; i++) begin
      add_row(OP_WRITE, (64'd1 << (PAGE_BITS + 4 * i)) + 64'(i),
              64'h0123_4567_89AB_CDEF ^ 64'(i), 1, 64'h0, 1'b0, 1'b1, 1'b0);
    end
    add_row(OP_WRITE, 64'h5555_5555_5555_5555, 64'h3C3C_3C3C_3C3C_3C3C, 1,
            64'h0, 1'b0, 1'b0, 1'b1);
    add_row(OP_READ,  64'h5555_5555_5555_5555, 64'h0, 1, 64'h0, 1'b0, 1'b0, 1'b0);
    add_row(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFE, 64'h1234_5678_9ABC_DEF0, 1,
            64'h0, 1'b1, 1'b0, 1'b0);
    add_row(OP_READ,  64'hFFFF_FFFF_FFFF_FFFE, 64'h0, 0, 64'h0, 1'b0, 1'b0, 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      send_access(row.op, row.addr, row.wdata, $urandom_range(0, 2), row.typed, row.want);
    end

    burst_left = 0;
    for (int n = 0; n < 1800; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        gap = 0;
      end
      burst_left--;
      pick  = $urandom_range(0, 99);
      op    = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      wdata = {$urandom, $urandom};
      addr  = page_pool[$urandom_range(0, page_pool.size() - 1)];
      if (pick < 80) begin
        addr[PAGE_BITS-1:0] = PAGE_BITS'($urandom);
      end else if (pick < 90) begin
        addr = addr ^ (64'd1 << $urandom_range(PAGE_BITS, ADDR_W - 1));
      end else begin
        addr = {$urandom, $urandom};
      end
      send_access(op, addr, wdata, gap, 0, '0);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    for (int w = 0; w < 20000 && pending_results.size() > 0; w++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("items missing", 64'(pending_results.size()), 64'h0);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
